// File: src/mmsrf_pkg.sv
// ----------------------------------------------------------------------------
// mmsrf_pkg
// Shared types and constants of the multi-motor speed ramp framer.
// ----------------------------------------------------------------------------
package mmsrf_pkg;

  localparam int NUM_MOTORS = 4;
  localparam int NUM_SLOTS  = 4;

  localparam int SPEED_W    = 16;
  localparam int STEP_W     = 15;
  localparam int MASK_W     = 4;
  localparam int OP_W       = 3;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PROD_W     = 24;

  typedef logic signed [SPEED_W-1:0] speed_t;

  localparam speed_t SAT_HI    = 16'sd32767;
  localparam speed_t SAT_LO    = -16'sd32767;
  localparam speed_t SPEED_MIN = 16'sh8000;
  localparam int     SCALE     = 100;

  localparam speed_t              UPPER_RST   = 16'sd300;
  localparam speed_t              LOWER_RST   = -16'sd300;
  localparam logic [STEP_W-1:0]   STEP_RST    = 15'd5;
  localparam logic [MASK_W-1:0]   REVERSE_RST = 4'b1100;

  typedef enum logic [OP_W-1:0] {
    OP_TICK       = 3'd0,
    OP_SET_IMM    = 3'd1,
    OP_SET_SMOOTH = 3'd2,
    OP_STOP       = 3'd3,
    OP_SET_ALL    = 3'd4
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UPPER   = 2'd0,
    CFG_LOWER   = 2'd1,
    CFG_STEP    = 2'd2,
    CFG_REVERSE = 2'd3
  } cfg_idx_e;

  // Per-motor update strobes, already qualified by the input handshake
  typedef struct packed {
    logic              tick;
    logic              load_all;
    logic              load_tgt;
    logic              clear;
    speed_t            req;
    logic [STEP_W-1:0] step;
    logic              reverse;
  } motor_cmd_t;

endpackage

// File: src/mmsrf_if.sv
// ----------------------------------------------------------------------------
// mmsrf interfaces
// Valid/ready channels: command input, frame output and configuration write.
// ----------------------------------------------------------------------------
interface mmsrf_in_if;
  logic                           valid;
  logic                           ready;
  logic [mmsrf_pkg::OP_W-1:0]     opcode;
  logic [mmsrf_pkg::IDX_W-1:0]    motor_index;
  logic signed [mmsrf_pkg::SPEED_W-1:0] speed_request;

  modport source (output valid, opcode, motor_index, speed_request, input ready);
  modport sink   (input valid, opcode, motor_index, speed_request, output ready);
endinterface

interface mmsrf_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mmsrf_pkg::SPEED_W-1:0] slot0_command;
  logic signed [mmsrf_pkg::SPEED_W-1:0] slot1_command;
  logic signed [mmsrf_pkg::SPEED_W-1:0] slot2_command;
  logic signed [mmsrf_pkg::SPEED_W-1:0] slot3_command;

  modport source (output valid, slot0_command, slot1_command, slot2_command,
                  slot3_command, input ready);
  modport sink   (input valid, slot0_command, slot1_command, slot2_command,
                  slot3_command, output ready);
endinterface

interface mmsrf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [mmsrf_pkg::CFG_IDX_W-1:0]    index;
  logic [mmsrf_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: src/mmsrf_motor.sv
// ----------------------------------------------------------------------------
// mmsrf_motor
// One motor channel: target, ramped speed and frame slot, with ramp and
// command scaling (sign, x100, saturation).
// ----------------------------------------------------------------------------
module mmsrf_motor (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mmsrf_pkg::motor_cmd_t   cmd_i,
  output mmsrf_pkg::speed_t       slot_o
);

  localparam int DIFF_W = mmsrf_pkg::SPEED_W + 1;

  mmsrf_pkg::speed_t tgt_q, tgt_d;
  mmsrf_pkg::speed_t rmp_q, rmp_d;
  mmsrf_pkg::speed_t slot_q, slot_d;

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] step_s;
  logic signed [DIFF_W-1:0] rmp_up;
  logic signed [DIFF_W-1:0] rmp_dn;
  mmsrf_pkg::speed_t        ramp_next;
  mmsrf_pkg::speed_t        scale_in;
  mmsrf_pkg::speed_t        scaled;

  // Reversal at 17 bits so the most negative speed flips cleanly
  function automatic mmsrf_pkg::speed_t scale_cmd(mmsrf_pkg::speed_t s, logic rev);
    logic signed [DIFF_W-1:0]                v;
    logic signed [mmsrf_pkg::PROD_W-1:0]     p;
    mmsrf_pkg::speed_t                       r;
    v = rev ? -DIFF_W'(s) : DIFF_W'(s);
    p = mmsrf_pkg::PROD_W'(v) * mmsrf_pkg::PROD_W'(mmsrf_pkg::SCALE);
    if (p > mmsrf_pkg::PROD_W'(mmsrf_pkg::SAT_HI)) begin
      r = mmsrf_pkg::SAT_HI;
    end else if (p < mmsrf_pkg::PROD_W'(mmsrf_pkg::SAT_LO)) begin
      r = mmsrf_pkg::SAT_LO;
    end else begin
      r = p[mmsrf_pkg::SPEED_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    diff   = DIFF_W'(tgt_q) - DIFF_W'(rmp_q);
    step_s = signed'({2'b00, cmd_i.step});
    rmp_up = DIFF_W'(rmp_q) + step_s;
    rmp_dn = DIFF_W'(rmp_q) - step_s;
    if (diff > step_s) begin
      ramp_next = rmp_up[mmsrf_pkg::SPEED_W-1:0];
    end else if (diff < -step_s) begin
      ramp_next = rmp_dn[mmsrf_pkg::SPEED_W-1:0];
    end else begin
      ramp_next = tgt_q;
    end
    scale_in = cmd_i.load_all ? cmd_i.req : ramp_next;
    scaled   = scale_cmd(scale_in, cmd_i.reverse);
  end

  always_comb begin
    tgt_d  = tgt_q;
    rmp_d  = rmp_q;
    slot_d = slot_q;
    if (cmd_i.clear) begin
      tgt_d  = '0;
      rmp_d  = '0;
      slot_d = '0;
    end else if (cmd_i.load_all) begin
      tgt_d  = cmd_i.req;
      rmp_d  = cmd_i.req;
      slot_d = scaled;
    end else if (cmd_i.load_tgt) begin
      tgt_d  = cmd_i.req;
    end else if (cmd_i.tick) begin
      rmp_d  = ramp_next;
      slot_d = scaled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q  <= '0;
      rmp_q  <= '0;
      slot_q <= '0;
    end else begin
      tgt_q  <= tgt_d;
      rmp_q  <= rmp_d;
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// File: src/multi_motor_speed_ramp_framer.sv
// ----------------------------------------------------------------------------
// multi_motor_speed_ramp_framer
// Four-motor speed ramp building the four-slot command frame.
// ----------------------------------------------------------------------------
// Channels: in_i takes commands (tick, set immediate, set smooth, stop, set
// all smooth), out_o delivers frames of four slot commands in 0.01 rpm,
// cfg_i writes the speed limits, ramp step and reverse mask.
// Every command is completed in the cycle its transaction is taken: the
// motor state registers update at that edge and, for ticks, immediate sets
// and stops on a valid motor, the frame is shown on out_o in the next cycle.
// Throughput is one command per cycle while out_o is not stalled; the slot
// registers themselves act as the output register, so a new command is
// taken in the same cycle the pending frame is taken.
// While a frame waits on a stalled receiver, in_i.ready is low; nothing is
// dropped. Smooth sets and ignored commands produce no frame.
// Reset clears all speeds and slots to zero and loads the default limits
// (+/-300 rpm), step 5 and reverse mask for motors 2 and 3. The
// configuration port is always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module multi_motor_speed_ramp_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmsrf_in_if.sink    in_i,
  mmsrf_out_if.source out_o,
  mmsrf_cfg_if.sink   cfg_i
);

  mmsrf_pkg::speed_t                    upper_q;
  mmsrf_pkg::speed_t                    lower_q;
  logic [mmsrf_pkg::STEP_W-1:0]         step_q;
  logic [mmsrf_pkg::MASK_W-1:0]         reverse_q;
  logic                                 out_valid_q, out_valid_d;

  logic                                 accept;
  logic                                 idx_ok;
  logic                                 is_tick, is_imm, is_smooth, is_stop, is_all;
  logic                                 emit;
  mmsrf_pkg::speed_t                    req;
  mmsrf_pkg::motor_cmd_t                cmd [mmsrf_pkg::NUM_SLOTS];
  mmsrf_pkg::speed_t                    slot_w [mmsrf_pkg::NUM_SLOTS];

  // Configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= mmsrf_pkg::UPPER_RST;
      lower_q   <= mmsrf_pkg::LOWER_RST;
      step_q    <= mmsrf_pkg::STEP_RST;
      reverse_q <= mmsrf_pkg::REVERSE_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mmsrf_pkg::CFG_UPPER:   upper_q   <= signed'(cfg_i.data);
        mmsrf_pkg::CFG_LOWER:   lower_q   <= signed'(cfg_i.data);
        mmsrf_pkg::CFG_STEP:    step_q    <= cfg_i.data[mmsrf_pkg::STEP_W-1:0];
        mmsrf_pkg::CFG_REVERSE: reverse_q <= cfg_i.data[mmsrf_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // Command decode
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign idx_ok     = in_i.motor_index < mmsrf_pkg::IDX_W'(mmsrf_pkg::NUM_MOTORS);

  always_comb begin
    is_tick   = 1'b0;
    is_imm    = 1'b0;
    is_smooth = 1'b0;
    is_stop   = 1'b0;
    is_all    = 1'b0;
    case (in_i.opcode)
      mmsrf_pkg::OP_TICK:       is_tick   = 1'b1;
      mmsrf_pkg::OP_SET_IMM:    is_imm    = 1'b1;
      mmsrf_pkg::OP_SET_SMOOTH: is_smooth = 1'b1;
      mmsrf_pkg::OP_STOP:       is_stop   = 1'b1;
      mmsrf_pkg::OP_SET_ALL:    is_all    = 1'b1;
      default: ;
    endcase
  end

  // When the limits cross, requests above the upper limit take it, all others the lower
  always_comb begin
    if (in_i.speed_request > upper_q) begin
      req = upper_q;
    end else if (in_i.speed_request < lower_q) begin
      req = lower_q;
    end else begin
      req = in_i.speed_request;
    end
  end

  assign emit = accept && (is_tick || ((is_imm || is_stop) && idx_ok));

  for (genvar i = 0; i < mmsrf_pkg::NUM_SLOTS; i++) begin : g_slot
    if (i < mmsrf_pkg::NUM_MOTORS) begin : g_motor
      logic sel;
      assign sel = in_i.motor_index == mmsrf_pkg::IDX_W'(i);
      always_comb begin
        cmd[i].tick     = accept && is_tick;
        cmd[i].load_all = accept && is_imm && sel;
        cmd[i].load_tgt = accept && ((is_smooth && sel) || is_all);
        cmd[i].clear    = accept && is_stop && sel;
        cmd[i].req      = req;
        cmd[i].step     = step_q;
        cmd[i].reverse  = reverse_q[i];
      end
      mmsrf_motor u_motor (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd[i]),
        .slot_o (slot_w[i])
      );
    end else begin : g_unused
      assign cmd[i]    = '0;
      assign slot_w[i] = '0;
    end
  end

  // Output valid; payload comes straight from the slot registers
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.slot0_command = slot_w[0];
  assign out_o.slot1_command = slot_w[1];
  assign out_o.slot2_command = slot_w[2];
  assign out_o.slot3_command = slot_w[3];

  // Checks
  a_tick_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_tick |=> out_valid_q)
    else $error("tick did not produce a frame");

  a_smooth_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (is_smooth || is_all) |=> !out_valid_q)
    else $error("smooth set produced a frame");

  a_bad_index_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (is_imm || is_stop) && !idx_ok |=> !out_valid_q)
    else $error("out-of-range motor produced a frame");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_w[0] != mmsrf_pkg::SPEED_MIN && slot_w[1] != mmsrf_pkg::SPEED_MIN &&
    slot_w[2] != mmsrf_pkg::SPEED_MIN && slot_w[3] != mmsrf_pkg::SPEED_MIN)
    else $error("slot command outside saturation range");

  a_slots_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> $stable(slot_w[0]) && $stable(slot_w[3]))
    else $error("slot changed under a pending frame");

endmodule
